@@ rtl/core/bkd_pkg.sv @@
package bkd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH = 7;
   localparam int DIGIT_WIDTH = 6;
   localparam int PROD_WIDTH = VALUE_WIDTH + RADIX_WIDTH;
   localparam int LEVEL_WIDTH = $clog2(VALUE_WIDTH);
   localparam int STACK_DEPTH = VALUE_WIDTH - 1;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [RADIX_WIDTH-1:0] radix_type;
   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [PROD_WIDTH-1:0] prod_type;
   typedef logic [LEVEL_WIDTH-1:0] level_type;

   localparam radix_type RADIX_RESET = RADIX_WIDTH'(10);
   localparam radix_type RADIX_MIN = RADIX_WIDTH'(2);
   localparam radix_type RADIX_MAX = RADIX_WIDTH'(36);
   localparam digit_type DECIMAL_LIMIT = DIGIT_WIDTH'(10);
   localparam char_type CHAR_ZERO = CHAR_WIDTH'(48);
   localparam char_type CHAR_A = CHAR_WIDTH'(65);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_CMP,
      ST_DIGIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic mult;
      logic grow;
      logic sub;
      logic emit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic prod_le_rest;
      logic rest_ge_place;
      logic level_zero;
      logic out_free;
   } stat_type;

   // Clamp the radix register into 2..36
   function automatic radix_type effective_radix(radix_type raw);
      radix_type k;
      k = raw;
      if (k < RADIX_MIN) k = RADIX_MIN;
      if (k > RADIX_MAX) k = RADIX_MAX;
      return k;
   endfunction

   // Map a digit value to its ASCII character
   function automatic char_type digit_ascii(digit_type d);
      char_type c;
      if (d < DECIMAL_LIMIT) begin
         c = CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         c = CHAR_A + CHAR_WIDTH'(d - DECIMAL_LIMIT);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/bkd_channels.sv @@
interface bkd_req_if;
   logic valid;
   logic ready;
   bkd_pkg::value_type value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface bkd_rsp_if;
   logic valid;
   logic ready;
   bkd_pkg::char_type digit_char;
   logic last_digit;
   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

interface bkd_csr_if;
   logic valid;
   logic ready;
   bkd_pkg::radix_type radix;
   modport source (output valid, output radix, input ready);
   modport sink (input valid, input radix, output ready);
endinterface

@@ rtl/core/bkd_ctrl.sv @@
module bkd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bkd_pkg::stat_type stat,
   output bkd_pkg::cmd_type  cmd
);
   import bkd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.prod_le_rest) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (!stat.rest_ge_place && stat.out_free && stat.level_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_CMP: begin
            cmd.grow = stat.prod_le_rest;
         end
         ST_DIGIT: begin
            cmd.sub = stat.rest_ge_place;
            cmd.emit = !stat.rest_ge_place && stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/bkd_dp.sv @@
module bkd_dp (
   input  logic              clock,
   input  logic              reset,
   input  bkd_pkg::value_type req_value,
   bkd_rsp_if.source         rsp_bus,
   bkd_csr_if.sink           csr_bus,
   input  bkd_pkg::cmd_type  cmd,
   output bkd_pkg::stat_type stat
);
   import bkd_pkg::*;

   radix_type radix_ff;
   radix_type k;
   value_type rest_ff;
   value_type place_ff;
   prod_type  prod_ff;
   level_type level_ff;
   digit_type dcount_ff;
   char_type  char_ff;
   logic      last_ff;
   logic      rsp_valid_ff;
   value_type stack_ff [STACK_DEPTH];

   // Radix register, always ready
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_bus.valid) begin
         radix_ff <= csr_bus.radix;
      end
   end

   assign k = effective_radix(radix_ff);

   // Status to controller
   assign stat.prod_le_rest = prod_ff <= PROD_WIDTH'(rest_ff);
   assign stat.rest_ge_place = rest_ff >= place_ff;
   assign stat.level_zero = level_ff == '0;
   assign stat.out_free = !rsp_valid_ff || rsp_bus.ready;

   // Next power of k
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= PROD_WIDTH'(place_ff) * PROD_WIDTH'(k);
      end
   end

   // Power stack: entry e holds k to the power e+1
   always_ff @(posedge clock) begin
      if (cmd.grow) begin
         stack_ff[level_ff] <= prod_ff[VALUE_WIDTH-1:0];
      end
   end

   // Search, subtract and step down one place per digit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rest_ff <= req_value;
         place_ff <= VALUE_WIDTH'(1);
         level_ff <= '0;
         dcount_ff <= '0;
      end else if (cmd.grow) begin
         place_ff <= prod_ff[VALUE_WIDTH-1:0];
         level_ff <= level_ff + LEVEL_WIDTH'(1);
      end else if (cmd.sub) begin
         rest_ff <= rest_ff - place_ff;
         dcount_ff <= dcount_ff + DIGIT_WIDTH'(1);
      end else if (cmd.emit) begin
         dcount_ff <= '0;
         if (level_ff != '0) begin
            level_ff <= level_ff - LEVEL_WIDTH'(1);
            if (level_ff == LEVEL_WIDTH'(1)) begin
               place_ff <= VALUE_WIDTH'(1);
            end else begin
               place_ff <= stack_ff[level_ff - LEVEL_WIDTH'(2)];
            end
         end
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= digit_ascii(dcount_ff);
         last_ff <= level_ff == '0;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.digit_char = char_ff;
   assign rsp_bus.last_digit = last_ff;

endmodule

@@ rtl/core/base_k_digits_high_first.sv @@
// Channel | Dir | Word                       | Notes
// req_bus | in  | value [31:0]               | taken only while the engine is idle
// rsp_bus | out | digit_char [6:0], last_digit | held in an output register
// csr_bus | in  | radix [5:0]                | always ready, reset value 10
//
// The power search runs a multiply state, then a compare state, for each power; each digit
// is found by repeated subtraction of its place, one subtract per cycle.
// Reset is synchronous and active high; it clears the state machine, the output
// valid and sets the radix to 10. A stalled rsp_bus holds the engine at the next
// digit; the last digit may wait in the output register while a new word is taken.
module base_k_digits_high_first (
   input logic       clock,
   input logic       reset,
   bkd_req_if.sink   req_bus,
   bkd_rsp_if.source rsp_bus,
   bkd_csr_if.sink   csr_bus
);
   import bkd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bkd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_bus.value),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ rtl/core/bkd_checker.sv @@
module bkd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bkd_pkg::char_type digit_char,
   input logic              last_digit
);
   import bkd_pkg::*;

   // Output word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(digit_char) && $stable(last_digit))
      else $error("rsp word changed while stalled");

   // Only digit characters leave the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digit_char >= CHAR_ZERO && digit_char <= CHAR_ZERO + CHAR_WIDTH'(9))
                 || (digit_char >= CHAR_A && digit_char <= CHAR_A + CHAR_WIDTH'(25)))
      else $error("rsp digit_char is not a digit");

   // Engine is busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while engine busy");

   // Nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind base_k_digits_high_first bkd_checker u_bkd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .digit_char (rsp_bus.digit_char),
   .last_digit (rsp_bus.last_digit)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import bkd_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [63:0] VALUE_TOP = 64'hFFFF_FFFF;

   typedef struct {
      char_type digit_char;
      logic     last_digit;
   } digit_word_type;

   logic clock;
   logic reset;

   bkd_req_if req_bus();
   bkd_rsp_if rsp_bus();
   bkd_csr_if csr_bus();

   digit_word_type digits_due[$];
   radix_type      radix_now;
   bit             idle_enable;
   int unsigned    error_count;
   int unsigned    cycle_count;
   int unsigned    ready_hold;

   base_k_digits_high_first DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Map the register into the usable base range
   function automatic logic [63:0] clamp_radix(radix_type raw);
      logic [63:0] k;
      k = 64'(raw);
      if (k < 64'(RADIX_MIN)) k = 64'(RADIX_MIN);
      if (k > 64'(RADIX_MAX)) k = 64'(RADIX_MAX);
      return k;
   endfunction

   // Queue the digits of one value, most significant first
   function automatic void predict_digits(value_type v);
      logic [63:0]    k;
      logic [63:0]    rest;
      logic [63:0]    place;
      logic [63:0]    d;
      digit_word_type w;
      k = clamp_radix(radix_now);
      rest = 64'(v);
      place = 64'd1;
      while (place <= rest / k) place = place * k;
      while (place > 0) begin
         d = rest / place;
         rest = rest % place;
         if (d < 64'(DECIMAL_LIMIT)) begin
            w.digit_char = CHAR_ZERO + char_type'(d);
         end else begin
            w.digit_char = CHAR_A + char_type'(d - 64'(DECIMAL_LIMIT));
         end
         w.last_digit = (place == 64'd1);
         digits_due.push_back(w);
         place = place / k;
      end
   endfunction

   // Pick a value with a bias toward powers, small numbers and short widths
   function automatic value_type pick_value();
      logic [63:0] k;
      logic [63:0] p;
      int          e;
      k = clamp_radix(radix_now);
      case ($urandom_range(0, 5))
         0: return value_type'($urandom_range(0, 40 * 40));
         1: return value_type'($urandom >> $urandom_range(0, 31));
         2: begin
            p = 64'd1;
            e = $urandom_range(0, 31);
            while (e > 0 && p * k <= VALUE_TOP) begin
               p = p * k;
               e--;
            end
            case ($urandom_range(0, 2))
               0: return value_type'(p - 64'd1);
               1: return value_type'(p);
               default: return value_type'((p == VALUE_TOP) ? p : p + 64'd1);
            endcase
         end
         3: return ($urandom_range(0, 1) == 0) ? value_type'(0) : value_type'(VALUE_TOP);
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic radix_type pick_radix();
      if ($urandom_range(0, 3) == 0) begin
         return radix_type'($urandom_range(0, 63));
      end
      return radix_type'($urandom_range(2, 36));
   endfunction

   // Drive rsp ready, with stall bursts while idling is on
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         ready_hold <= $urandom_range(1, 16) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each accepted digit word with the oldest expectation
   always @(posedge clock) begin
      digit_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (digits_due.size() == 0) begin
            $error("digit_char unexpected word, actual %0d", rsp_bus.digit_char);
            error_count++;
         end else begin
            w = digits_due.pop_front();
            if (rsp_bus.digit_char !== w.digit_char) begin
               $error("digit_char expected %0d actual %0d", w.digit_char, rsp_bus.digit_char);
               error_count++;
            end
            if (rsp_bus.last_digit !== w.last_digit) begin
               $error("last_digit expected %0d actual %0d", w.last_digit, rsp_bus.last_digit);
               error_count++;
            end
         end
      end
   end

   // Present one value, wait for its handshake and queue its digits
   task automatic send_value(input value_type v);
      int gap;
      gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.value <= value_type'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      predict_digits(v);
   endtask

   // Drop req valid and wait until every digit has come out
   task automatic drain_digits();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radix(input radix_type r);
      drain_digits();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.radix <= r;
      do @(posedge clock); while (!csr_bus.ready);
      radix_now = r;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Base 10 out of reset: zero, carries across powers, full width
   task automatic test_reset_radix();
      send_value(value_type'(0));
      send_value(value_type'(9));
      send_value(value_type'(10));
      send_value(value_type'(99));
      send_value(value_type'(100));
      send_value(value_type'(1000000000));
      send_value(value_type'(VALUE_TOP));
   endtask

   // Smallest and largest base: longest and widest digit runs
   task automatic test_radix_extremes();
      write_radix(radix_type'(2));
      send_value(value_type'(0));
      send_value(value_type'(1));
      send_value(value_type'(32'h8000_0000));
      send_value(value_type'(VALUE_TOP));
      write_radix(radix_type'(36));
      send_value(value_type'(35));
      send_value(value_type'(36));
      send_value(value_type'(1295));
      send_value(value_type'(VALUE_TOP));
   endtask

   // Register values outside 2..36 clamp to the nearest end
   task automatic test_radix_clamps();
      write_radix(radix_type'(0));
      send_value(value_type'(5));
      write_radix(radix_type'(1));
      send_value(value_type'(VALUE_TOP));
      write_radix(radix_type'(37));
      send_value(value_type'(35));
      write_radix(radix_type'(63));
      send_value(value_type'(VALUE_TOP));
      write_radix(radix_type'(16));
      send_value(value_type'(32'h0123_ABCD));
   endtask

   // Random values in base 2, 36, 10 and then random bases, with stalls on both sides
   task automatic test_random_values(input int phases, input int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         case (ph)
            0: write_radix(radix_type'(2));
            1: write_radix(radix_type'(36));
            2: write_radix(radix_type'(10));
            default: write_radix(pick_radix());
         endcase
         for (int i = 0; i < per_phase; i++) send_value(pick_value());
      end
   endtask

   // Back to back values with no idling at all
   task automatic test_unstalled_tail(input int count);
      drain_digits();
      idle_enable = 1'b0;
      write_radix(pick_radix());
      for (int i = 0; i < count; i++) send_value(pick_value());
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.radix = '0;
      reset = 1'b1;
      radix_now = RADIX_RESET;
      idle_enable = 1'b1;
      error_count = 0;
      cycle_count = 0;
      ready_hold = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_radix();
      test_radix_extremes();
      test_radix_clamps();
      test_random_values(8, 30);
      test_unstalled_tail(40);

      drain_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (digits_due.size() != 0) begin
         $error("digit_char expected %0d more words, actual none", digits_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ base_k_digits_high_first.f @@
rtl/core/bkd_pkg.sv
rtl/core/bkd_channels.sv
rtl/core/bkd_ctrl.sv
rtl/core/bkd_dp.sv
rtl/core/base_k_digits_high_first.sv
rtl/core/bkd_checker.sv
tb/tb.sv
